// File: rtl/gaat_pkg.sv
`default_nettype none

package gaat_pkg;

    // Table geometry.
    localparam int CAPACITY  = 16;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);

    // Fixed field widths of the command and response words.
    localparam int KIND_W    = 3;
    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 5;

    // Generation counter starts here after reset.
    localparam logic [DATA_W-1:0] GEN_START = DATA_W'(1);
    localparam logic [DATA_W-1:0] GEN_MAX   = '1;

    // Operation codes.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT    = 3'd0,
        KIND_GET    = 3'd1,
        KIND_REMOVE = 3'd2,
        KIND_CLEAR  = 3'd3,
        KIND_BUMP   = 3'd4,
        KIND_SWEEP  = 3'd5
    } kind_t;

    typedef logic [DATA_W-1:0]   word_t;
    typedef logic [IDX_W-1:0]    idx_t;
    typedef logic [CNT_W-1:0]    cnt_t;
    typedef logic [CAPACITY-1:0] mask_t;
    typedef word_t               word_arr_t [CAPACITY];

    // Result of the parallel compare over all entries.
    typedef struct packed {
        logic  hit;
        idx_t  hit_idx;
        logic  free;
        idx_t  free_idx;
        mask_t stale;
    } lookup_t;

endpackage

`default_nettype wire

// File: rtl/gaat_chan_if.sv
`default_nettype none

// Command channel: one operation per word.
interface gaat_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] age_floor;

    modport source (output valid, kind, key, value, age_floor, input ready);
    modport sink   (input valid, kind, key, value, age_floor, output ready);
endinterface

// Response channel: one word per command.
interface gaat_rsp_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [31:0] value_out;
    logic [4:0]  removed_count;
    logic [4:0]  entry_count;

    modport source (output valid, ok, value_out, removed_count, entry_count, input ready);
    modport sink   (input valid, ok, value_out, removed_count, entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/gaat_lookup.sv
`default_nettype none

module gaat_lookup (
    input  wire gaat_pkg::word_t     key,
    input  wire gaat_pkg::word_t     age_floor,
    input  wire gaat_pkg::mask_t     valid_mask,
    input  wire gaat_pkg::word_arr_t keys,
    input  wire gaat_pkg::word_arr_t stamps,
    output gaat_pkg::lookup_t        result
);
    import gaat_pkg::*;

    mask_t match;
    mask_t stale;

    // Compare the key and the stamp of every entry in parallel.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            match[i] = valid_mask[i] && (keys[i] == key) && (key != '0);
            stale[i] = valid_mask[i] && (stamps[i] < age_floor);
        end
    end

    // Lowest matching slot and lowest free slot.
    always_comb
    begin
        result          = '0;
        result.hit      = |match;
        result.free     = ~&valid_mask;
        result.stale    = stale;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                result.hit_idx = IDX_W'(i);
            end
            if (!valid_mask[i])
            begin
                result.free_idx = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/generation_aged_assoc_table.sv
// Fully associative key/value table of 16 entries with generation aging.
//
// Channels: cmd carries one operation word (kind, key, value, age_floor)
// and rsp returns exactly one word per command (ok, value_out, removed_count,
// entry_count), in command order. A word moves when valid and ready are both
// high at a rising edge of clk.
//
// A command accepted into the command register moves into the response
// register once that register is empty or its word is taken, and rsp.valid
// rises as the response register is loaded.
// Throughput: one command per cycle while the receiver keeps rsp.ready high.
// The key compare, the free slot search and the stale stamp compare all run
// in parallel over the 16 entries between the command and response registers.
//
// Reset (rst_n low, asynchronous) invalidates every entry, sets the
// generation to 1 and the entry count to 0; no clearing pass is needed.
// When the receiver holds rsp.ready low the response register keeps its
// word, and one more command can wait in the command register; cmd.ready
// then drops until the response is taken.
`default_nettype none

module generation_aged_assoc_table (
    input  wire        clk,
    input  wire        rst_n,
    gaat_cmd_if.sink   cmd,
    gaat_rsp_if.source rsp
);
    import gaat_pkg::*;

    // Command register.
    logic           s1_valid_reg;
    logic [KIND_W-1:0] s1_kind_reg;
    word_t          s1_key_reg;
    word_t          s1_value_reg;
    word_t          s1_min_gen_reg;

    // Response register.
    logic           rsp_valid_reg;
    logic           rsp_ok_reg;
    word_t          rsp_value_reg;
    logic [OUT_CNT_W-1:0] rsp_removed_reg;
    logic [OUT_CNT_W-1:0] rsp_count_reg;

    // Table state.
    mask_t          valid_reg;
    mask_t          valid_next;
    word_arr_t      key_reg;
    word_arr_t      value_reg;
    word_arr_t      stamp_reg;
    word_t          gen_reg;
    word_t          gen_next;
    cnt_t           count_reg;
    cnt_t           count_next;

    // Entry write controls.
    logic           wr_entry;
    logic           wr_stamp;
    idx_t           wr_idx;

    // Results of the current command.
    logic           ok;
    word_t          vout;
    cnt_t           removed;

    lookup_t        lk;
    logic           advance;

    // The command stage moves on when it holds a command and the response register is empty or its word is taken.
    assign advance   = s1_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign cmd.ready = !s1_valid_reg || advance;

    gaat_lookup u_lookup (
        .key            (s1_key_reg),
        .age_floor      (s1_min_gen_reg),
        .valid_mask     (valid_reg),
        .keys           (key_reg),
        .stamps         (stamp_reg),
        .result         (lk)
    );

    // Command register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            s1_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            s1_kind_reg    <= cmd.kind;
            s1_key_reg     <= cmd.key;
            s1_value_reg   <= cmd.value;
            s1_min_gen_reg <= cmd.age_floor;
        end
    end

    // Operation decode and next table state.
    always_comb
    begin
        valid_next = valid_reg;
        gen_next   = gen_reg;
        count_next = count_reg;
        wr_entry   = 1'b0;
        wr_stamp   = 1'b0;
        wr_idx     = lk.hit_idx;
        ok         = 1'b0;
        vout       = '0;
        removed    = '0;
        case (s1_kind_reg)
            KIND_PUT:
            begin
                if (s1_key_reg != '0)
                begin
                    if (lk.hit)
                    begin
                        wr_entry = 1'b1;
                        ok       = 1'b1;
                    end
                    else if (lk.free)
                    begin
                        wr_idx             = lk.free_idx;
                        wr_entry           = 1'b1;
                        valid_next[wr_idx] = 1'b1;
                        count_next         = count_reg + CNT_W'(1);
                        ok                 = 1'b1;
                    end
                end
            end
            KIND_GET:
            begin
                if (lk.hit)
                begin
                    wr_stamp = 1'b1;
                    vout     = value_reg[lk.hit_idx];
                    ok       = 1'b1;
                end
            end
            KIND_REMOVE:
            begin
                if (lk.hit)
                begin
                    valid_next[lk.hit_idx] = 1'b0;
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    ok = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                valid_next = '0;
                count_next = '0;
                if (gen_reg != GEN_MAX)
                begin
                    gen_next = gen_reg + DATA_W'(1);
                end
                ok = 1'b1;
            end
            KIND_BUMP:
            begin
                if (gen_reg != GEN_MAX)
                begin
                    gen_next = gen_reg + DATA_W'(1);
                end
                ok = 1'b1;
            end
            KIND_SWEEP:
            begin
                valid_next = valid_reg & ~lk.stale;
                removed    = CNT_W'($countones(lk.stale));
                count_next = (count_reg > removed) ? (count_reg - removed) : '0;
                ok         = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Control state of the table.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            gen_reg   <= GEN_START;
            count_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
            gen_reg   <= gen_next;
            count_reg <= count_next;
        end
    end

    // Entry payload; an entry is only read while its valid bit is set.
    always_ff @(posedge clk)
    begin
        if (advance && wr_entry)
        begin
            key_reg[wr_idx]   <= s1_key_reg;
            value_reg[wr_idx] <= s1_value_reg;
            stamp_reg[wr_idx] <= gen_reg;
        end
        else if (advance && wr_stamp)
        begin
            stamp_reg[wr_idx] <= gen_reg;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_ok_reg      <= ok;
            rsp_value_reg   <= vout;
            rsp_removed_reg <= OUT_CNT_W'(removed);
            rsp_count_reg   <= OUT_CNT_W'(count_next);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.ok            = rsp_ok_reg;
    assign rsp.value_out     = rsp_value_reg;
    assign rsp.removed_count = rsp_removed_reg;
    assign rsp.entry_count   = rsp_count_reg;

    // The entry count always equals the number of valid entries.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CNT_W'($countones(valid_reg)))
        else $error("entry count differs from number of valid entries");

    // The generation never reaches zero.
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        gen_reg != '0)
        else $error("generation is zero");

    // The generation never goes backward.
    a_gen_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> gen_reg >= $past(gen_reg))
        else $error("generation decreased");

    // A clear leaves no valid entry.
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_kind_reg == KIND_CLEAR) |=> valid_reg == '0)
        else $error("entries survived a clear");

    // A response is only loaded from a live command.
    a_rsp_from_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid_reg && !s1_valid_reg) |=> !rsp_valid_reg)
        else $error("response appeared without a command");

endmodule

`default_nettype wire

// File: sim/gaat_table_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the table, keeps its own copy of the table state,
// works out the response word for every accepted command word and compares
// it with the responses in order.
module gaat_table_checker (
    input  wire  clk,
    input  wire  rst_n,
    gaat_cmd_if  cmd,
    gaat_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   checked,
    output int   get_hits,
    output int   full_refusals,
    output int   swept
);
    import gaat_pkg::*;

    typedef struct packed {
        logic                 ok;
        word_t                value_out;
        logic [OUT_CNT_W-1:0] removed;
        logic [OUT_CNT_W-1:0] entries;
    } table_rsp_t;

    // Shadow copy of the table.
    logic        live   [CAPACITY];
    word_t       keys   [CAPACITY];
    word_t       vals   [CAPACITY];
    word_t       stamps [CAPACITY];
    word_t       generation;
    int unsigned occupancy;

    // Response words still owed by the block, oldest first.
    table_rsp_t  owed_q [$];

    // Lowest valid entry holding this key, or -1. Key zero never matches.
    function automatic int slot_of(word_t k);
        int i;
        slot_of = -1;
        if (k != '0) begin
            for (i = CAPACITY - 1; i >= 0; i--) begin
                if (live[i] && keys[i] == k) begin
                    slot_of = i;
                end
            end
        end
    endfunction

    // An invalidated entry has all of its fields zeroed.
    function automatic void drop_entry(int i);
        live[i]   = 1'b0;
        keys[i]   = '0;
        vals[i]   = '0;
        stamps[i] = '0;
    endfunction

    // The generation saturates at its maximum.
    function automatic void advance_generation();
        if (generation != GEN_MAX) begin
            generation = generation + 1'b1;
        end
    endfunction

    // Applies one command word to the shadow table and returns its response.
    function automatic table_rsp_t apply_op(logic [KIND_W-1:0] kind, word_t key,
                                            word_t value, word_t min_gen);
        table_rsp_t r;
        int         s;
        int         i;
        int         n;
        r = '0;
        n = 0;
        case (kind)
            KIND_PUT:
            begin
                if (key != '0) begin
                    s = slot_of(key);
                    // A new key takes the lowest free slot, if there is one.
                    if (s < 0) begin
                        for (i = CAPACITY - 1; i >= 0; i--) begin
                            if (!live[i]) begin
                                s = i;
                            end
                        end
                        if (s >= 0) begin
                            occupancy++;
                        end
                    end
                    if (s >= 0) begin
                        live[s]   = 1'b1;
                        keys[s]   = key;
                        vals[s]   = value;
                        stamps[s] = generation;
                        r.ok      = 1'b1;
                    end
                    else begin
                        full_refusals++;
                    end
                end
            end
            KIND_GET:
            begin
                s = slot_of(key);
                if (s >= 0) begin
                    stamps[s]   = generation;
                    r.value_out = vals[s];
                    r.ok        = 1'b1;
                    get_hits++;
                end
            end
            KIND_REMOVE:
            begin
                s = slot_of(key);
                if (s >= 0) begin
                    drop_entry(s);
                    if (occupancy > 0) begin
                        occupancy--;
                    end
                    r.ok = 1'b1;
                end
            end
            KIND_CLEAR:
            begin
                for (i = 0; i < CAPACITY; i++) begin
                    drop_entry(i);
                end
                occupancy = 0;
                advance_generation();
                r.ok = 1'b1;
            end
            KIND_BUMP:
            begin
                advance_generation();
                r.ok = 1'b1;
            end
            KIND_SWEEP:
            begin
                for (i = 0; i < CAPACITY; i++) begin
                    if (live[i] && stamps[i] < min_gen) begin
                        drop_entry(i);
                        n++;
                    end
                end
                occupancy = (occupancy > n) ? occupancy - n : 0;
                r.removed = OUT_CNT_W'(n);
                r.ok      = 1'b1;
                swept    += n;
            end
            default:
            begin
            end
        endcase
        r.entries = OUT_CNT_W'(occupancy);
        return r;
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        mismatches++;
        $display("%0t: mismatch in %s of response %0d: got 0x%h, expected 0x%h",
                 $time, what, checked, got, want);
    endtask

    // Responses are checked before the command of the same edge is predicted,
    // since a command cannot be answered at the edge that accepts it.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        table_rsp_t want;
        int         delta;
        int         i;
        if (!rst_n) begin
            for (i = 0; i < CAPACITY; i++) begin
                drop_entry(i);
            end
            generation    = GEN_START;
            occupancy     = 0;
            owed_q.delete();
            mismatches    = 0;
            checked       = 0;
            get_hits      = 0;
            full_refusals = 0;
            swept         = 0;
            outstanding  <= 0;
        end
        else begin
            delta = 0;
            if (rsp.valid && rsp.ready) begin
                checked++;
                if (owed_q.size() == 0) begin
                    report_mismatch("unexpected response", rsp.value_out, '0);
                end
                else begin
                    want  = owed_q.pop_front();
                    delta = -1;
                    if (rsp.ok !== want.ok) begin
                        report_mismatch("ok", word_t'(rsp.ok), word_t'(want.ok));
                    end
                    if (rsp.value_out !== want.value_out) begin
                        report_mismatch("value_out", rsp.value_out, want.value_out);
                    end
                    if (rsp.removed_count !== want.removed) begin
                        report_mismatch("removed_count", word_t'(rsp.removed_count),
                                        word_t'(want.removed));
                    end
                    if (rsp.entry_count !== want.entries) begin
                        report_mismatch("entry_count", word_t'(rsp.entry_count),
                                        word_t'(want.entries));
                    end
                end
            end
            if (cmd.valid && cmd.ready) begin
                owed_q.push_back(apply_op(cmd.kind, cmd.key, cmd.value, cmd.age_floor));
                delta = delta + 1;
            end
            outstanding <= outstanding + delta;
        end
    end

endmodule

// File: sim/tb_generation_aged_assoc_table.sv
`timescale 1ns / 100ps

module tb_generation_aged_assoc_table;
    import gaat_pkg::*;

    localparam int POOL_SIZE    = 24;
    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 80;
    localparam int RANDOM_OPS   = 250;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    gaat_cmd_if cmd ();
    gaat_rsp_if rsp ();

    int    mismatches;
    int    outstanding;
    int    checked;
    int    get_hits;
    int    full_refusals;
    int    swept;

    int    send_idle_pct = 0;
    int    recv_idle_pct = 0;
    bit    hold_req      = 1'b0;
    int    hold_left     = 0;
    int    ops_sent      = 0;
    int    quiet_cycles  = 0;
    word_t gen_hint      = GEN_START;
    word_t key_pool [POOL_SIZE];

    generation_aged_assoc_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp)
    );

    gaat_table_checker u_table_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .rsp           (rsp),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked),
        .get_hits      (get_hits),
        .full_refusals (full_refusals),
        .swept         (swept)
    );

    always #5 clk = ~clk;

    // Offers one command word, with random idle cycles ahead of it, and
    // returns at the edge that accepts it.
    task automatic send_op(logic [KIND_W-1:0] k, word_t key, word_t value, word_t min_gen);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid     <= 1'b1;
        cmd.kind      <= k;
        cmd.key       <= key;
        cmd.value     <= value;
        cmd.age_floor <= min_gen;
        do @(posedge clk); while (!cmd.ready);
        ops_sent++;
        if (k == KIND_BUMP || k == KIND_CLEAR) begin
            gen_hint = gen_hint + 1'b1;
        end
    endtask

    // Stops offering and waits until every owed response has been taken.
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Mostly keys from a small pool so that gets and removes hit, with some
    // fresh keys and the odd zero key.
    function automatic word_t pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            return '0;
        end
        else if (r < 14) begin
            return $urandom;
        end
        return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Sweeps mostly aim near the current generation so they remove a few
    // entries rather than all or none.
    function automatic word_t pick_min_gen();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return gen_hint - word_t'($urandom_range(0, 2));
        end
        else if (r < 60) begin
            return gen_hint + 1'b1;
        end
        else if (r < 70) begin
            return '0;
        end
        else if (r < 80) begin
            return '1;
        end
        return $urandom;
    endfunction

    task automatic random_op();
        int                r;
        logic [KIND_W-1:0] k;
        r = $urandom_range(0, 199);
        if (r < 76) begin
            k = KIND_PUT;
        end
        else if (r < 132) begin
            k = KIND_GET;
        end
        else if (r < 152) begin
            k = KIND_REMOVE;
        end
        else if (r < 168) begin
            k = KIND_SWEEP;
        end
        else if (r < 192) begin
            k = KIND_BUMP;
        end
        else if (r < 194) begin
            k = KIND_CLEAR;
        end
        else begin
            k = KIND_W'($urandom_range(6, 7));
        end
        send_op(k, pick_key(), $urandom,
                (k == KIND_SWEEP) ? pick_min_gen() : word_t'($urandom));
    endtask

    // Receiver: random stalls, or a long hold-off when one is requested.
    initial
    begin
        rsp.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                rsp.ready <= 1'b0;
                hold_left--;
            end
            else if (hold_req) begin
                hold_req   = 1'b0;
                hold_left  = HOLD_CYCLES - 1;
                rsp.ready <= 1'b0;
            end
            else begin
                rsp.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready)) begin
                quiet_cycles = 0;
            end
            else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles, %0d responses owed",
                         STALL_LIMIT, outstanding);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int i;
        int p;
        cmd.valid     = 1'b0;
        cmd.kind      = '0;
        cmd.key       = '0;
        cmd.value     = '0;
        cmd.age_floor = '0;
        for (i = 0; i < POOL_SIZE; i++) begin
            do key_pool[i] = $urandom; while (key_pool[i] == '0);
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero key, unused kinds, filling the table, a put refused on
        // a full table, overwrite, hits and misses, restamp and sweeps.
        send_op(KIND_PUT, '0, 32'h1234_5678, '0);
        send_op(KIND_GET, '0, '0, '0);
        send_op(KIND_REMOVE, '0, '0, '0);
        send_op(KIND_W'(6), 32'h0000_0001, '0, '0);
        send_op(KIND_W'(7), '1, '1, '1);
        send_op(KIND_PUT, '1, '1, '0);
        send_op(KIND_PUT, 32'h0000_0001, '0, '1);
        for (i = 0; i < CAPACITY - 2; i++) begin
            send_op(KIND_PUT, key_pool[i], $urandom, $urandom);
        end
        send_op(KIND_PUT, key_pool[CAPACITY - 2], 32'hDEAD_BEEF, '0);
        send_op(KIND_PUT, 32'h0000_0001, 32'hA5A5_A5A5, '0);
        send_op(KIND_GET, '1, '0, '0);
        send_op(KIND_REMOVE, 32'h0000_0001, '0, '0);
        send_op(KIND_REMOVE, 32'h0000_0001, '0, '0);
        send_op(KIND_BUMP, '0, '0, '0);
        send_op(KIND_GET, '1, '0, '0);
        send_op(KIND_SWEEP, '0, '0, gen_hint);
        send_op(KIND_SWEEP, '0, '0, '1);
        send_op(KIND_CLEAR, '0, '0, '0);
        wait_drained();

        // Random phases: slow receiver, then slow sender, then no idling.
        for (p = 0; p < 3; p++) begin
            send_idle_pct = (p == 0) ? 21 : (p == 1) ? 81 : 0;
            recv_idle_pct = (p == 0) ? 81 : (p == 1) ? 21 : 0;
            for (i = 0; i < 20; i++) begin
                send_op(KIND_PUT, key_pool[i], $urandom, $urandom);
            end
            for (i = 0; i < RANDOM_OPS; i++) begin
                if (p == 0 && i == 100) begin
                    hold_req = 1'b1;
                end
                random_op();
            end
            wait_drained();
        end
        repeat (8) @(posedge clk);

        $display("Sent %0d commands of every kind, zero and pooled keys; %0d responses checked.",
                 ops_sent, checked);
        $display("Saw %0d get hits, %0d puts refused on a full table, %0d entries swept.",
                 get_hits, full_refusals, swept);
        if (mismatches == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end
        else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
